// ===== rtl/rag_pkg.sv =====
package rag_pkg;

    localparam int POS_W  = 11;
    localparam int DATA_W = 32;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 2'd0,
        KIND_MAX  = 2'd1,
        KIND_GCD  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ACC_SUM,
        ACC_MAX,
        ACC_GCD
    } acc_mode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_LEAF,
        S_A_LEAFW,
        S_U_RL,
        S_U_RR,
        S_U_CMB,
        S_U_GCD,
        S_Q_TEST,
        S_Q_RCHK,
        S_Q_ACC,
        S_Q_GCD,
        S_Q_SHIFT,
        S_Q_END,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] mx;
        logic [DATA_W-1:0] gcd;
    } node_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } gcd_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] value;
    } gcd_rsp_t;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ===== rtl/rag_ifs.sv =====
interface rag_op_if
    import rag_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         left;
    logic [POS_W-1:0]         right;
    logic signed [DATA_W-1:0] delta;

    modport source (output valid, kind, left, right, delta, input ready);
    modport sink   (input valid, kind, left, right, delta, output ready);
endinterface

interface rag_res_if
    import rag_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] answer;

    modport source (output valid, answer, input ready);
    modport sink   (input valid, answer, output ready);
endinterface

// ===== rtl/rag_gcd.sv =====
module rag_gcd
    import rag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  gcd_req_t req,
    output gcd_rsp_t rsp
);

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [4:0]        k_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DATA_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (a_reg == '0 || b_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
            k_reg <= '0;
        end
        else if (busy_reg)
        begin
            priority if (a_reg == '0)
            begin
                value_reg <= b_reg << k_reg;
            end
            else if (b_reg == '0)
            begin
                value_reg <= a_reg << k_reg;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_reg <= (a_reg - b_reg) >> 1;
            end
            else
            begin
                b_reg <= (b_reg - a_reg) >> 1;
            end
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

// ===== rtl/range_add_gcd_max_tree_top.sv =====
// Range add: one leaf update, a second if right < element count; each climbs L = log2(2*MAX_ELEMENTS) - 1 levels.
// Queries: about 4 * L node visits, plus a run of G for each node merged by gcd.
// G is the binary gcd unit; one word at a time, not ready while busy.
// A finished word waits in the output register while the next word is taken.
// After reset every node of the memory is cleared in turn, with ready low.
// The element count resets to 1024, clamped to MAX_ELEMENTS.
module range_add_gcd_max_tree_top
    import rag_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    rag_op_if.sink           op,
    rag_res_if.source        res,
    input  logic             cfg_we,
    input  logic [POS_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(2 * MAX_ELEMENTS);
    localparam int LW = AW + 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int RESET_COUNT = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

    state_t            state_reg;
    state_t            state_next;
    logic [CW-1:0]     count_reg;
    logic [POS_W-1:0]  left_reg;
    logic [POS_W-1:0]  right_reg;
    logic [DATA_W-1:0] delta_reg;
    logic [DATA_W-1:0] x_reg;
    logic              second_reg;
    logic [AW-1:0]     p_reg;
    logic [LW-1:0]     l_reg;
    logic [LW-1:0]     r_reg;
    logic [DATA_W-1:0] acc_reg;
    acc_mode_t         mode_reg;
    logic              after_reg;
    node_t             hold_reg;
    logic [AW-1:0]     clr_reg;
    logic [DATA_W-1:0] result_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] answer_reg;

    node_t             mem [2 * MAX_ELEMENTS];
    node_t             rd_q;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    node_t             mem_wdata;
    logic [AW-1:0]     mem_raddr;

    gcd_req_t          gcd_req;
    gcd_rsp_t          gcd_rsp;

    logic [31:0]       n32;
    logic [31:0]       left32;
    logic [31:0]       right32;
    logic              add_ok;
    logic              q_ok;
    logic              accept;
    logic              out_load;
    logic [DATA_W-1:0] leaf_sum;
    logic [DATA_W-1:0] leaf_mag;
    logic [CW-1:0]     count_wr;

    rag_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (gcd_req),
        .rsp   (gcd_rsp)
    );

    assign n32     = 32'(count_reg);
    assign left32  = 32'(op.left);
    assign right32 = 32'(op.right);
    assign add_ok  = (op.left != '0) && (left32 <= n32) && (op.right >= op.left);
    assign q_ok    = add_ok && (right32 <= n32);
    assign accept  = op.valid && op.ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || res.ready);
    assign leaf_sum = rd_q.sum + x_reg;
    assign leaf_mag = magnitude(leaf_sum);

    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            count_wr = CW'(1);
        end
        else if (32'(cfg_wdata) > 32'(MAX_ELEMENTS))
        begin
            count_wr = CW'(MAX_ELEMENTS);
        end
        else
        begin
            count_wr = CW'(cfg_wdata);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(2 * MAX_ELEMENTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (op.valid)
                begin
                    unique case (kind_t'(op.kind))
                        KIND_ADD:  state_next = add_ok ? S_A_LEAF : S_IDLE;
                        KIND_NONE: state_next = S_IDLE;
                        KIND_MAX:  state_next = (q_ok && op.left != op.right) ? S_Q_TEST : S_OUT;
                        KIND_GCD:  state_next = q_ok ? S_Q_TEST : S_OUT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_A_LEAF:  state_next = S_A_LEAFW;
            S_A_LEAFW: state_next = S_U_RL;
            S_U_RL:    state_next = S_U_RR;
            S_U_RR:    state_next = S_U_CMB;
            S_U_CMB:   state_next = S_U_GCD;
            S_U_GCD:
            begin
                if (gcd_rsp.done)
                begin
                    if (p_reg != AW'(1))
                    begin
                        state_next = S_U_RL;
                    end
                    else
                    begin
                        state_next = second_reg ? S_A_LEAF : S_IDLE;
                    end
                end
            end
            S_Q_TEST:
            begin
                if (l_reg < r_reg)
                begin
                    state_next = l_reg[0] ? S_Q_ACC : S_Q_RCHK;
                end
                else
                begin
                    state_next = S_Q_END;
                end
            end
            S_Q_RCHK:  state_next = r_reg[0] ? S_Q_ACC : S_Q_SHIFT;
            S_Q_ACC:
            begin
                if (mode_reg == ACC_GCD)
                begin
                    state_next = S_Q_GCD;
                end
                else
                begin
                    state_next = after_reg ? S_Q_SHIFT : S_Q_RCHK;
                end
            end
            S_Q_GCD:
            begin
                if (gcd_rsp.done)
                begin
                    state_next = after_reg ? S_Q_SHIFT : S_Q_RCHK;
                end
            end
            S_Q_SHIFT: state_next = S_Q_TEST;
            S_Q_END:
            begin
                if (mode_reg == ACC_SUM && left_reg != right_reg)
                begin
                    state_next = S_Q_TEST;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:     state_next = out_load ? S_IDLE : S_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        op.ready      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = p_reg;
        mem_wdata     = '0;
        mem_raddr     = p_reg;
        gcd_req.start = 1'b0;
        gcd_req.a     = hold_reg.gcd;
        gcd_req.b     = rd_q.gcd;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            S_IDLE:    op.ready = 1'b1;
            S_A_LEAFW:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{sum: leaf_sum, mx: leaf_mag, gcd: leaf_mag};
            end
            S_U_RL:    mem_raddr = p_reg << 1;
            S_U_RR:    mem_raddr = (p_reg << 1) | AW'(1);
            S_U_CMB:   gcd_req.start = 1'b1;
            S_U_GCD:
            begin
                mem_we    = gcd_rsp.done;
                mem_wdata = '{sum: hold_reg.sum, mx: hold_reg.mx, gcd: gcd_rsp.value};
            end
            S_Q_TEST:  mem_raddr = l_reg[AW-1:0];
            S_Q_RCHK:  mem_raddr = r_reg[AW-1:0] - AW'(1);
            S_Q_ACC:
            begin
                gcd_req.start = (mode_reg == ACC_GCD);
                gcd_req.a     = acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= CW'(RESET_COUNT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                count_reg <= count_wr;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            answer_reg <= result_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    left_reg   <= op.left;
                    right_reg  <= op.right;
                    delta_reg  <= op.delta;
                    x_reg      <= op.delta;
                    second_reg <= right32 < n32;
                    p_reg      <= AW'(32'(MAX_ELEMENTS) + left32 - 32'd1);
                    acc_reg    <= '0;
                    result_reg <= '0;
                    if (kind_t'(op.kind) == KIND_MAX)
                    begin
                        mode_reg <= ACC_MAX;
                        l_reg    <= LW'(32'(MAX_ELEMENTS) + left32);
                        r_reg    <= LW'(32'(MAX_ELEMENTS) + right32);
                    end
                    else
                    begin
                        mode_reg <= ACC_SUM;
                        l_reg    <= LW'(MAX_ELEMENTS);
                        r_reg    <= LW'(32'(MAX_ELEMENTS) + left32);
                    end
                end
            end
            S_A_LEAFW: p_reg <= p_reg >> 1;
            S_U_RR:    hold_reg <= rd_q;
            S_U_CMB:
            begin
                hold_reg.sum <= hold_reg.sum + rd_q.sum;
                hold_reg.mx  <= (hold_reg.mx > rd_q.mx) ? hold_reg.mx : rd_q.mx;
            end
            S_U_GCD:
            begin
                if (gcd_rsp.done)
                begin
                    if (p_reg != AW'(1))
                    begin
                        p_reg <= p_reg >> 1;
                    end
                    else if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        x_reg      <= ~delta_reg + 1'b1;
                        p_reg      <= AW'(32'(MAX_ELEMENTS) + 32'(right_reg));
                    end
                end
            end
            S_Q_TEST:
            begin
                if (l_reg < r_reg && l_reg[0])
                begin
                    l_reg     <= l_reg + 1'b1;
                    after_reg <= 1'b0;
                end
            end
            S_Q_RCHK:
            begin
                if (r_reg[0])
                begin
                    r_reg     <= r_reg - 1'b1;
                    after_reg <= 1'b1;
                end
            end
            S_Q_ACC:
            begin
                if (mode_reg == ACC_SUM)
                begin
                    acc_reg <= acc_reg + rd_q.sum;
                end
                else if (mode_reg == ACC_MAX)
                begin
                    acc_reg <= (rd_q.mx > acc_reg) ? rd_q.mx : acc_reg;
                end
            end
            S_Q_GCD:
            begin
                if (gcd_rsp.done)
                begin
                    acc_reg <= gcd_rsp.value;
                end
            end
            S_Q_SHIFT:
            begin
                l_reg <= l_reg >> 1;
                r_reg <= r_reg >> 1;
            end
            S_Q_END:
            begin
                if (mode_reg == ACC_SUM && left_reg != right_reg)
                begin
                    acc_reg  <= magnitude(acc_reg);
                    mode_reg <= ACC_GCD;
                    l_reg    <= LW'(32'(MAX_ELEMENTS) + 32'(left_reg));
                    r_reg    <= LW'(32'(MAX_ELEMENTS) + 32'(right_reg));
                end
                else
                begin
                    result_reg <= acc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.valid  = out_valid_reg;
    assign res.answer = answer_reg;

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result word raised outside the output step");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && 32'(count_reg) <= 32'(MAX_ELEMENTS))
        else $error("element count out of range");

    a_gcd_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        gcd_req.start |-> !gcd_rsp.busy)
        else $error("gcd started while busy");

    a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_CLEAR) |-> mem_waddr != '0)
        else $error("tree write to unused node");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rag_pkg::*;

    localparam int DEPTH = 1024;
    localparam int SETTLE_CYCLES = 2500;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [POS_W-1:0] cfg_wdata;

    rag_op_if op_bus();
    rag_res_if res_bus();

    range_add_gcd_max_tree_top #(.MAX_ELEMENTS(DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .op(op_bus),
        .res(res_bus),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    logic [DATA_W-1:0] diff_mirror [1:DEPTH];
    int unsigned span_count;
    logic [DATA_W-1:0] answer_q[$];
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int answers_seen;
    int words_sent;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [DATA_W-1:0] abs_word(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [DATA_W-1:0] gcd_word(input logic [DATA_W-1:0] x,
                                                   input logic [DATA_W-1:0] y);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] t;
        a = x;
        b = y;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [DATA_W-1:0] prefix_sum(input int upto);
        logic [DATA_W-1:0] acc;
        acc = 0;
        for (int i = 1; i <= upto; i++)
            acc = acc + diff_mirror[i];
        return acc;
    endfunction

    // update the mirror of the difference array, return whether an answer follows
    function automatic bit apply_word(input logic [KIND_W-1:0] kind, input int lo,
                                      input int hi, input logic [DATA_W-1:0] delta,
                                      output logic [DATA_W-1:0] answer);
        logic [DATA_W-1:0] acc;
        int n;
        n = span_count;
        answer = 0;
        if (kind == KIND_ADD)
        begin
            if (lo == 0 || lo > n || hi < lo)
                return 0;
            diff_mirror[lo] = diff_mirror[lo] + delta;
            if (hi < n)
                diff_mirror[hi + 1] = diff_mirror[hi + 1] - delta;
            return 0;
        end
        if (kind == KIND_NONE)
            return 0;
        if (lo == 0 || lo > n || hi < lo || hi > n)
            return 1;
        if (kind == KIND_MAX)
        begin
            acc = 0;
            for (int i = lo + 1; i <= hi; i++)
                if (abs_word(diff_mirror[i]) > acc)
                    acc = abs_word(diff_mirror[i]);
            answer = acc;
        end
        else
        begin
            acc = prefix_sum(lo);
            if (lo == hi)
                answer = acc;
            else
            begin
                acc = abs_word(acc);
                for (int i = lo + 1; i <= hi; i++)
                    acc = gcd_word(acc, abs_word(diff_mirror[i]));
                answer = acc;
            end
        end
        return 1;
    endfunction

    always @(posedge clk)
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        logic [DATA_W-1:0] want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            answers_seen++;
            if (answer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer %h", res_bus.answer);
            end
            else
            begin
                want = answer_q.pop_front();
                if (res_bus.answer !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("answer mismatch: expected %h got %h", want, res_bus.answer);
                end
            end
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input int lo, input int hi,
                             input logic [DATA_W-1:0] delta);
        logic [DATA_W-1:0] answer;
        if ($urandom_range(99) < send_idle_pct)
        begin
            op_bus.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        op_bus.valid <= 1'b1;
        op_bus.kind <= kind;
        op_bus.left <= lo[POS_W-1:0];
        op_bus.right <= hi[POS_W-1:0];
        op_bus.delta <= delta;
        @(posedge clk);
        while (!op_bus.ready)
            @(posedge clk);
        words_sent++;
        if (apply_word(kind, lo & 11'h7ff, hi & 11'h7ff, delta, answer))
            answer_q.push_back(answer);
    endtask

    // hold off until every answer is back and any trailing add has finished
    task automatic drain();
        op_bus.valid <= 1'b0;
        @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value[POS_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        span_count = (value == 0) ? 1 : (value > DEPTH ? DEPTH : value);
        @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_delta(input logic [DATA_W-1:0] base);
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3, 4: return $urandom;
            default: return base * ($urandom_range(16) - 8);
        endcase
    endfunction

    task automatic test_directed();
        send_word(KIND_MAX, 1, DEPTH, 0);
        send_word(KIND_GCD, 1, 1, 0);
        send_word(KIND_ADD, 1, DEPTH, 32'h8000_0000);
        send_word(KIND_GCD, 1, 1, 0);
        send_word(KIND_ADD, 5, 5, 32'h7fff_ffff);
        send_word(KIND_ADD, 6, 2047, 32'hffff_fff4);
        send_word(KIND_MAX, 1, DEPTH, 0);
        send_word(KIND_MAX, 4, 6, 0);
        send_word(KIND_MAX, 7, 7, 0);
        send_word(KIND_GCD, 5, 7, 0);
        send_word(KIND_GCD, 6, DEPTH, 0);
        send_word(KIND_NONE, 1, 10, 32'h1234_5678);
        send_word(KIND_ADD, 0, 4, 9);
        send_word(KIND_ADD, 9, 3, 9);
        send_word(KIND_ADD, 1025, 2047, 9);
        send_word(KIND_MAX, 0, 3, 0);
        send_word(KIND_GCD, 4, 2, 0);
        send_word(KIND_GCD, 1, 1025, 0);
        send_word(KIND_MAX, 2047, 2047, 0);
        write_count(3);
        send_word(KIND_ADD, 2, 2047, 6);
        send_word(KIND_GCD, 1, 3, 0);
        send_word(KIND_MAX, 1, 4, 0);
        write_count(0);
        send_word(KIND_GCD, 1, 1, 0);
        write_count(2047);
        send_word(KIND_GCD, 1, DEPTH, 0);
    endtask

    task automatic test_random(input int count, input int n_hint);
        logic [DATA_W-1:0] base;
        logic [KIND_W-1:0] kind;
        int lo;
        int hi;
        write_count(n_hint);
        base = $urandom_range(1, 12);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(19) == 0)
                base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 40);
            case ($urandom_range(9))
                0, 1, 2, 3: kind = KIND_ADD;
                4, 5: kind = KIND_MAX;
                9: kind = KIND_W'($urandom_range(3));
                default: kind = KIND_GCD;
            endcase
            if ($urandom_range(9) == 0)
            begin
                lo = $urandom_range(2047);
                hi = $urandom_range(2047);
            end
            else
            begin
                lo = $urandom_range(1, span_count);
                hi = ($urandom_range(4) == 0) ? lo : $urandom_range(lo, span_count);
            end
            send_word(kind, lo, hi, pick_delta(base));
        end
    endtask

    task automatic test_pause();
        drain();
        send_word(KIND_GCD, 1, span_count, 0);
        send_word(KIND_MAX, 1, span_count, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        op_bus.valid = 1'b0;
        op_bus.kind = '0;
        op_bus.left = '0;
        op_bus.right = '0;
        op_bus.delta = '0;
        res_bus.ready = 1'b0;
        mismatches = 0;
        answers_seen = 0;
        words_sent = 0;
        span_count = DEPTH;
        for (int i = 1; i <= DEPTH; i++)
            diff_mirror[i] = 0;
        send_idle_pct = 33;
        recv_idle_pct = 69;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(100, 16);
        test_random(100, DEPTH);
        send_idle_pct = 69;
        recv_idle_pct = 33;
        test_random(120, 5);
        test_pause();
        test_random(80, 1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(120, 40);
        test_random(100, 2);
        drain();
        $display("sent %0d words over element counts 1..1024, checked %0d answers",
                 words_sent, answers_seen);
        if (mismatches == 0 && answer_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #250ms;
        $display("timeout, %0d answers outstanding", answer_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
